// ----- rtl/core/ess_pkg.sv -----
package ess_pkg;

   // field widths
   localparam int FID_W   = 31;
   localparam int FOFF_W  = 48;
   localparam int LOFF_W  = 48;
   localparam int ELEN_W  = 32;
   localparam int SLICE_W = 33;
   localparam int PLEN_W  = 33;

   // packed channel widths (padded to whole bytes)
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 160;

   // defaults
   localparam int MAX_PIECES_DEF = 64;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 33'd1048576;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EVAL,
      ST_SEND
   } ess_state_type;

endpackage

// ----- rtl/core/extent_slice_splitter_top.sv -----
// Channel   | Dir | Payload
// ----------+-----+------------------------------------------------------------
// req_      | in  | tdata: file_id, file_offset, store_offset, extent_length
// rsp_      | out | tdata: piece fields; tlast: last_piece; tuser: too_many_pieces
// csr_      | in  | wr_en / wr_data: slice_size
//
// One request is accepted in ST_IDLE; ST_DIV then uses the shared subtractor to find
// file_offset mod slice_size (one quotient bit per cycle), ST_EVAL classifies it,
// then pieces go out at one per cycle while the consumer keeps rsp_tready high.
// With slice_size zero the request skips the division and goes out as one piece.
// req_tready is high only while idle; rsp_tready low holds the current piece.
// Reset is synchronous; it loads slice_size with 1 MiB and returns to idle.
module extent_slice_splitter_top #(
   parameter int MAX_PIECES = ess_pkg::MAX_PIECES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // config
   input  logic                             csr_wr_en,
   input  logic [ess_pkg::SLICE_W-1:0]      csr_wr_data,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [30:0] file_id, [78:31] file_offset, [126:79] store_offset,
   // [158:127] extent_length, [159] zero
   input  logic [ess_pkg::REQ_DATA_W-1:0]   req_tdata,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [30:0] piece_file_id, [78:31] piece_file_offset,
   // [126:79] piece_store_offset, [159:127] piece_length
   output logic [ess_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,  // last_piece
   output logic                             rsp_tuser   // too_many_pieces
);
   import ess_pkg::*;

   localparam int CAP_W    = SLICE_W + $clog2(MAX_PIECES + 1);
   localparam int DIV_STEPS = FOFF_W;
   localparam int CNT_W    = $clog2(DIV_STEPS);
   localparam int TOT_W    = SLICE_W + 1;

   ess_state_type state_ff, state_in;

   logic [SLICE_W-1:0] slice_ff;
   logic [CAP_W-1:0]   cap_ff;

   logic [FID_W-1:0]   fid_ff,  fid_in;
   logic [FOFF_W-1:0]  foff_ff, foff_in;
   logic [LOFF_W-1:0]  loff_ff, loff_in;
   logic [PLEN_W-1:0]  plen_ff, plen_in;
   logic               last_ff, last_in;
   logic               ovf_ff,  ovf_in;
   logic [TOT_W-1:0]   left_ff, left_in;
   logic [SLICE_W-1:0] rem_ff,  rem_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;

   // shared subtractor: operand minus slice_size
   logic [TOT_W-1:0]   sub_a;
   logic [TOT_W:0]     sub_diff;
   logic               sub_borrow;
   logic [TOT_W-1:0]   tot;

   assign sub_diff   = {1'b0, sub_a} - {2'b00, slice_ff};
   assign sub_borrow = sub_diff[TOT_W];
   assign tot        = {1'b0, rem_ff} + {2'b00, left_ff[ELEN_W-1:0]};

   // outputs
   assign rsp_tdata = {plen_ff, loff_ff, foff_ff, fid_ff};
   assign rsp_tlast = last_ff;
   assign rsp_tuser = ovf_ff;

   // sequencer: next state and datapath updates
   always_comb begin
      state_in   = state_ff;
      fid_in     = fid_ff;
      foff_in    = foff_ff;
      loff_in    = loff_ff;
      plen_in    = plen_ff;
      last_in    = last_ff;
      ovf_in     = ovf_ff;
      left_in    = left_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      sub_a      = left_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               fid_in  = req_tdata[FID_W-1:0];
               foff_in = req_tdata[FID_W +: FOFF_W];
               loff_in = req_tdata[FID_W+FOFF_W +: LOFF_W];
               left_in = {2'b00, req_tdata[FID_W+FOFF_W+LOFF_W +: ELEN_W]};
               rem_in  = '0;
               cnt_in  = CNT_W'(DIV_STEPS - 1);
               ovf_in  = 1'b0;
               if (slice_ff == '0) begin
                  // no slicing: pass through as one piece
                  plen_in  = {1'b0, req_tdata[FID_W+FOFF_W+LOFF_W +: ELEN_W]};
                  last_in  = 1'b1;
                  state_in = ST_SEND;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring remainder step, MSB of file offset first
            sub_a  = {rem_ff, foff_ff[cnt_ff]};
            rem_in = sub_borrow ? sub_a[SLICE_W-1:0] : sub_diff[SLICE_W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // tot = offset within slice + length; compare against one slice
            sub_a    = tot;
            state_in = ST_SEND;
            if (sub_borrow || (sub_diff == '0)) begin
               plen_in = {1'b0, left_ff[ELEN_W-1:0]};
               last_in = 1'b1;
            end else if (CAP_W'(tot) > cap_ff) begin
               fid_in  = '0;
               foff_in = '0;
               loff_in = '0;
               plen_in = '0;
               last_in = 1'b0;
               ovf_in  = 1'b1;
            end else begin
               plen_in = slice_ff - rem_ff;
               left_in = sub_diff[TOT_W-1:0];
               last_in = 1'b0;
            end
         end
         ST_SEND: begin
            rsp_tvalid = 1'b1;
            sub_a      = left_ff;
            if (rsp_tready) begin
               if (last_ff || ovf_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  foff_in = foff_ff + FOFF_W'(plen_ff);
                  loff_in = loff_ff + LOFF_W'(plen_ff);
                  if (!sub_borrow && (sub_diff != '0)) begin
                     plen_in = slice_ff;
                     left_in = sub_diff[TOT_W-1:0];
                  end else begin
                     plen_in = left_ff[PLEN_W-1:0];
                     last_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slice_ff <= SLICE_RESET;
         cap_ff   <= CAP_W'(SLICE_RESET) * CAP_W'(MAX_PIECES);
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            slice_ff <= csr_wr_data;
         end
         // largest span that still fits in MAX_PIECES slices
         cap_ff <= CAP_W'(slice_ff) * CAP_W'(MAX_PIECES);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fid_ff  <= fid_in;
      foff_ff <= foff_in;
      loff_ff <= loff_in;
      plen_ff <= plen_in;
      last_ff <= last_in;
      ovf_ff  <= ovf_in;
      left_ff <= left_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

`ifndef SYNTH
   // no new request while a piece is on offer
   a_busy_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while result pending");

   // overflow result carries zero fields and no last flag
   a_ovf_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> ((rsp_tdata == '0) && !rsp_tlast))
      else $error("overflow result not cleared");

   // pieces never exceed one slice when slicing is on
   a_piece_fits: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser && (slice_ff != '0)) |-> ({1'b0, plen_ff} <= {1'b0, slice_ff}))
      else $error("piece longer than slice");

   // final piece handshake returns the sequencer to idle
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && (rsp_tlast || rsp_tuser)) |=> req_tready)
      else $error("sequencer did not return to idle");

   // remainder is below the slice size once the division ends
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (rem_ff < slice_ff))
      else $error("remainder out of range");
`endif

endmodule

// ----- test/extent_slice_splitter_top_tb.sv -----
`timescale 1ns / 1ps

module extent_slice_splitter_top_tb;
   import ess_pkg::*;

   localparam int    MAX_PIECES  = MAX_PIECES_DEF;
   localparam int    CYCLE_LIMIT = 1_000_000;
   localparam int    DRAIN_WAIT  = 70;
   localparam logic [63:0] OFF_TOP = 64'h1_0000_0000_0000;  // 2^48

   // one expected or observed piece
   typedef struct packed {
      logic [FID_W-1:0]  fid;
      logic [FOFF_W-1:0] foff;
      logic [LOFF_W-1:0] loff;
      logic [PLEN_W-1:0] plen;
      logic              last;
      logic              ovf;
   } piece_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [SLICE_W-1:0]    csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   // testbench copy of the slice register and expected piece stream
   logic [SLICE_W-1:0] slice_model = SLICE_RESET;
   piece_type          pending_pieces[$];
   bit                 calm = 1'b0;      // no idling on either side
   int                 mismatches = 0;
   int                 cycle_count = 0;
   int                 extents_sent = 0;
   int                 pieces_seen = 0;
   int                 overflows_seen = 0;
   int                 slice_writes = 0;

   extent_slice_splitter_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic piece_type make_piece(logic [63:0] fid, logic [63:0] foff,
                                            logic [63:0] loff, logic [63:0] plen,
                                            logic last, logic ovf);
      piece_type p;
      p.fid  = fid[FID_W-1:0];
      p.foff = foff[FOFF_W-1:0];
      p.loff = loff[LOFF_W-1:0];
      p.plen = plen[PLEN_W-1:0];
      p.last = last;
      p.ovf  = ovf;
      return p;
   endfunction

   // cut one extent at slice boundaries and queue the pieces it must produce
   function automatic void split_extent(logic [FID_W-1:0] fid, logic [FOFF_W-1:0] foff,
                                        logic [LOFF_W-1:0] loff, logic [ELEN_W-1:0] len);
      logic [63:0] s, end_x, sl_start, sl_end_x, cnt, pos, lpos;
      s = 64'(slice_model);
      if (s == 0 || len == 0) begin
         pending_pieces.push_back(make_piece(fid, foff, loff, len, 1'b1, 1'b0));
         return;
      end
      end_x    = 64'(foff) + 64'(len);
      sl_start = 64'(foff) - (64'(foff) % s);
      sl_end_x = sl_start + s;
      if (end_x <= sl_end_x) begin
         pending_pieces.push_back(make_piece(fid, foff, loff, len, 1'b1, 1'b0));
         return;
      end
      cnt = (end_x - sl_start + s - 1) / s;
      if (cnt > 64'(MAX_PIECES)) begin
         pending_pieces.push_back(make_piece(0, 0, 0, 0, 1'b0, 1'b1));
         return;
      end
      pending_pieces.push_back(make_piece(fid, foff, loff, sl_end_x - foff, 1'b0, 1'b0));
      lpos = 64'(loff) + (sl_end_x - 64'(foff));
      pos  = sl_end_x;
      while (end_x > pos + s) begin
         pending_pieces.push_back(make_piece(fid, pos, lpos, s, 1'b0, 1'b0));
         lpos += s;
         pos  += s;
      end
      pending_pieces.push_back(make_piece(fid, pos, lpos, end_x - pos, 1'b1, 1'b0));
   endfunction

   // result checker
   always @(posedge clock) begin
      piece_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.fid  = rsp_tdata[30:0];
         got.foff = rsp_tdata[78:31];
         got.loff = rsp_tdata[126:79];
         got.plen = rsp_tdata[159:127];
         got.last = rsp_tlast;
         got.ovf  = rsp_tuser;
         pieces_seen++;
         if (got.ovf) overflows_seen++;
         if (pending_pieces.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected piece fid=%h foff=%h loff=%h len=%h last=%b ovf=%b",
                        got.fid, got.foff, got.loff, got.plen, got.last, got.ovf);
         end else begin
            want = pending_pieces.pop_front();
            if (got.fid !== want.fid || got.foff !== want.foff || got.loff !== want.loff ||
                got.plen !== want.plen || got.last !== want.last || got.ovf !== want.ovf) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("piece mismatch exp: fid=%h foff=%h loff=%h len=%h last=%b ovf=%b",
                           want.fid, want.foff, want.loff, want.plen, want.last, want.ovf);
                  $display("               got: fid=%h foff=%h loff=%h len=%h last=%b ovf=%b",
                           got.fid, got.foff, got.loff, got.plen, got.last, got.ovf);
               end
            end
         end
      end
   end

   // consumer backpressure in random bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 12);
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // present one request and hold it until accepted
   task automatic send_extent(logic [FID_W-1:0] fid, logic [FOFF_W-1:0] foff,
                              logic [LOFF_W-1:0] loff, logic [ELEN_W-1:0] len);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, len, loff, foff, fid};
      do @(posedge clock); while (!req_tready);
      split_extent(fid, foff, loff, len);
      extents_sent++;
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // stop sending and wait for every outstanding piece
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_pieces.size() == 0);
   endtask

   task automatic write_slice_size(logic [SLICE_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      slice_model = value;
      slice_writes++;
   endtask

   // reset value, passthrough cases, exact fit, 64 pieces and overflow, wrap
   task automatic test_default_slice();
      send_extent('1, '1, '1, 0);
      send_extent(31'h1234, 48'h1000, 48'h2000, 32'h100);
      send_extent(31'h55, 48'hFFFF0, 48'h0, 32'd16);
      send_extent(31'h56, 48'hFFFF0, 48'h10, 32'd17);
      send_extent(31'h0, 48'h0, 48'h0, 32'h0400_0000);
      send_extent(31'h1, 48'h1, 48'h0, 32'h0400_0000);
      send_extent('1, '1, '1, '1);
      send_extent(31'h7, 48'(OFF_TOP - 10), 48'(OFF_TOP - 4), 32'd100);
   endtask

   // slice sizes at the extremes of the register
   task automatic test_slice_extremes();
      write_slice_size(33'd1);
      send_extent(31'h2AAA_AAAA, 48'h5555_5555_5555, 48'h0, 32'd64);
      send_extent(31'h5555_5555, 48'h0, 48'hAAAA_AAAA_AAAA, 32'd65);
      send_extent(31'h3, 48'h9, 48'h9, 32'd1);
      write_slice_size(33'd0);
      send_extent(31'h11, 48'h8000_0000_0001, 48'h1, '1);
      send_extent(31'h12, 48'h3, 48'h4, 32'd0);
      write_slice_size(33'd3);
      send_extent(31'h13, 48'd5, 48'd100, 32'd10);
      write_slice_size(33'h1_0000_0000);
      send_extent(31'h14, 48'hFFFF_FFFF, 48'h1, '1);
      send_extent(31'h15, 48'h0, 48'h0, '1);
      write_slice_size('1);
      send_extent(31'h16, 48'h1_FFFF_FFFE, 48'h0, 32'd5);
      send_extent(31'h17, '1, 48'hFFFF_FFFF_0000, '1);
   endtask

   // random extents, mostly sized to need several pieces or to overflow
   task automatic random_extents(int count, logic [SLICE_W-1:0] s_size, bit gaps);
      logic [63:0] s, len64, foff64;
      int          sel, k;
      if (s_size != slice_model) write_slice_size(s_size);
      s = 64'(s_size);
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0:       len64 = 0;
            1:       len64 = rand64() % s;
            2:       len64 = 64'($urandom);
            default: begin
               k = $urandom_range(2, 66);
               len64 = 64'(k - 1) * s + rand64() % s;
            end
         endcase
         if (len64 > 64'hFFFF_FFFF) len64 = 64'hFFFF_FFFF;
         case ($urandom_range(0, 7))
            0:       foff64 = OFF_TOP - 64'($urandom_range(1, 5000));
            1:       foff64 = (rand64() % OFF_TOP) / s * s;
            default: foff64 = rand64();
         endcase
         if (gaps && !calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 12));
         if (!calm && $urandom_range(0, 29) == 0) drain();
         send_extent(31'($urandom), foff64[47:0], 48'(rand64()), len64[31:0]);
      end
   endtask

   task automatic test_random();
      logic [SLICE_W-1:0] big;
      big = {1'($urandom), 32'($urandom)};
      if (big == 0) big = 33'd1;
      random_extents(12, 33'd1, 1'b1);
      random_extents(12, 33'd7, 1'b1);
      random_extents(12, 33'd4096, 1'b1);
      random_extents(12, SLICE_RESET, 1'b1);
      random_extents(12, big, 1'b1);
      random_extents(12, 33'h1_0000_0000, 1'b1);
   endtask

   // closing stretch with both sides running flat out
   task automatic test_full_rate();
      drain();
      calm = 1'b1;
      random_extents(20, 33'($urandom_range(1, 65536)), 1'b0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_slice();
      test_slice_extremes();
      test_random();
      test_full_rate();

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d extents over %0d slice settings: %0d pieces, %0d overflows",
               extents_sent, slice_writes + 1, pieces_seen, overflows_seen);
      $display("mismatches: %0d, pieces still pending: %0d",
               mismatches, pending_pieces.size());
      if (mismatches == 0 && pending_pieces.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
